>>> rtl/core/btm_pkg.sv
// ----------------------------------------------------------------------------
// btm_pkg: shared definitions for the binary trie multiset core
// Sizes, operation and status codes, and the control and status structs that
// pass between the key shifter and the walk sequencer.
// ----------------------------------------------------------------------------
package btm_pkg;

   // Key walk depth and node pool size.
   localparam int KEY_BITS   = 32;
   localparam int POOL_NODES = 1024;

   // Width of the key word on the request channel.
   localparam int KEY_IN_W = 32;

   // Derived widths.
   localparam int NODE_W  = $clog2(POOL_NODES);
   localparam int FREE_W  = $clog2(POOL_NODES + 1);
   localparam int CNT_W   = $clog2(KEY_BITS + 1);
   localparam int COUNT_W = 32;
   localparam int SUM_W   = ((FREE_W > CNT_W) ? FREE_W : CNT_W) + 1;
   localparam int LINK_W  = 2 * NODE_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Operation codes on req_mode.
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_SEARCH = 2'd1;
   localparam logic [1:0] MODE_ERASE  = 2'd2;

   // Status codes on rsp_status.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_ABSENT    = 2'd1;
   localparam logic [1:0] STAT_POOL_FULL = 2'd2;
   localparam logic [1:0] STAT_SATURATED = 2'd3;

   // Commands to the key shifter.
   typedef struct packed {
      logic load;     // capture a new key and start from its top bit
      logic restart;  // rewind to the top bit of the held key
      logic shift;    // move on to the next lower bit
   } ksr_ctl_type;

   // What the key shifter reports back.
   typedef struct packed {
      logic             msb;     // key bit for the current trie level
      logic [CNT_W-1:0] remain;  // bits still to walk, current one included
      logic             done;    // no bits left
   } ksr_stat_type;

endpackage

>>> rtl/core/btm_ram.sv
// ----------------------------------------------------------------------------
// btm_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module btm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/btm_key_sr.sv
// ----------------------------------------------------------------------------
// btm_key_sr: key shift register
// Holds the accepted key and presents it one bit per step, most significant
// bit first, with a count of the bits still to walk.
// ----------------------------------------------------------------------------
module btm_key_sr (
   input  logic                           clock,
   input  logic                           reset,
   input  btm_pkg::ksr_ctl_type           ctl,
   input  logic [btm_pkg::KEY_IN_W-1:0]   key,
   output btm_pkg::ksr_stat_type          stat
);
   import btm_pkg::*;

   logic [KEY_BITS+KEY_IN_W-1:0] key_wide;
   logic [KEY_BITS-1:0]          key_ext;
   logic [KEY_BITS-1:0]          hold_ff, hold_in;
   logic [KEY_BITS-1:0]          sr_ff, sr_in;
   logic [CNT_W-1:0]             remain_ff, remain_in;

   // Bits above the request word count as zero; bits above the walk depth
   // are dropped.
   assign key_wide = {{KEY_BITS{1'b0}}, key};
   assign key_ext  = key_wide[KEY_BITS-1:0];

   // Next-state selection for the hold and shift registers.
   always_comb begin
      hold_in   = hold_ff;
      sr_in     = sr_ff;
      remain_in = remain_ff;
      if (ctl.load) begin
         hold_in   = key_ext;
         sr_in     = key_ext;
         remain_in = CNT_W'(KEY_BITS);
      end else if (ctl.restart) begin
         sr_in     = hold_ff;
         remain_in = CNT_W'(KEY_BITS);
      end else if (ctl.shift) begin
         sr_in     = {sr_ff[KEY_BITS-2:0], 1'b0};
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      sr_ff   <= sr_in;
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   assign stat.msb    = sr_ff[KEY_BITS-1];
   assign stat.remain = remain_ff;
   assign stat.done   = (remain_ff == '0);

endmodule

>>> rtl/core/binary_trie_multiset_core.sv
// ----------------------------------------------------------------------------
// binary_trie_multiset_core: multiset of keys kept as a binary trie
// Walks a node pool one key bit per cycle, most significant bit first, to
// search, insert or erase a key, and returns one result word per request.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_stall   req_mode, req_key
//   rsp_      out        rsp_valid / rsp_stall   rsp_found, rsp_status
//
// A check pass reads one node from the link and count memories per level.
// Insert and erase that change the trie add an update pass. The pool needs
// no clearing since only allocated nodes, which are written when allocated,
// are ever read. A stalled result waits in the output register while the
// next request is already walked.
// ----------------------------------------------------------------------------
module binary_trie_multiset_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic [btm_pkg::KEY_IN_W-1:0] req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic [1:0]                   rsp_status
);
   import btm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CHECK  = 4'b0010,
      S_UPDATE = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic               first_ff, first_in;
   logic               new_ff, new_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic               present_ff, present_in;
   logic               sat_ff, sat_in;
   logic               found_ff, found_in;
   logic [1:0]         status_ff, status_in;
   logic [FREE_W-1:0]  next_free_ff, next_free_in;
   logic [NODE_W-1:0]  root_zero_ff, root_zero_in;
   logic [NODE_W-1:0]  root_one_ff, root_one_in;
   logic [COUNT_W-1:0] root_count_ff, root_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   ksr_ctl_type        ksr_ctl;
   ksr_stat_type       ksr_stat;

   logic               link_we;
   logic [LINK_W-1:0]  link_wdata;
   logic [LINK_W-1:0]  link_rdata;
   logic               count_we;
   logic [COUNT_W-1:0] count_wdata;
   logic [COUNT_W-1:0] count_rdata;
   logic [NODE_W-1:0]  rd_node;

   logic [LINK_W-1:0]  node_links;
   logic [COUNT_W-1:0] node_count;
   logic [NODE_W-1:0]  child;
   logic               child_missing;
   logic               present_now;
   logic               present_end;
   logic               sat_now;
   logic [CNT_W-1:0]   needed;
   logic [SUM_W-1:0]   pool_sum;
   logic               pool_short;
   logic               is_insert;
   logic               accept;
   logic               rsp_free;
   logic [NODE_W-1:0]  new_node;
   logic [LINK_W-1:0]  links_upd;

   // Key bits are fed one per step by the shift register.
   btm_key_sr u_key_sr (
      .clock (clock),
      .reset (reset),
      .ctl   (ksr_ctl),
      .key   (req_key),
      .stat  (ksr_stat)
   );

   // Both child links of a node live in one word: one link high, zero link low.
   btm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (node_ff),
      .wr_data (link_wdata),
      .rd_addr (rd_node),
      .rd_data (link_rdata)
   );

   btm_ram #(.WIDTH(COUNT_W), .DEPTH(POOL_NODES)) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (node_ff),
      .wr_data (count_wdata),
      .rd_addr (rd_node),
      .rd_data (count_rdata)
   );

   // The current node is the root (in registers), a fresh node (all zero),
   // or a pool node whose read was issued on the previous cycle.
   always_comb begin
      if (first_ff) begin
         node_links = {root_one_ff, root_zero_ff};
         node_count = root_count_ff;
      end else if (new_ff) begin
         node_links = '0;
         node_count = '0;
      end else begin
         node_links = link_rdata;
         node_count = count_rdata;
      end
   end

   assign child         = ksr_stat.msb ? node_links[LINK_W-1:NODE_W]
                                       : node_links[NODE_W-1:0];
   assign child_missing = (child == '0);

   // Presence ignores the root count; saturation looks at every node.
   assign present_now = present_ff & (first_ff | (node_count != '0));
   assign sat_now     = sat_ff | (node_count == COUNT_MAX);
   assign present_end = present_now & ksr_stat.done;
   assign needed      = ksr_stat.done ? '0 : ksr_stat.remain;

   // Pool test: the nodes still to allocate must fit behind the free pointer.
   assign pool_sum   = SUM_W'(next_free_ff) + SUM_W'(needed);
   assign pool_short = (pool_sum > SUM_W'(POOL_NODES));

   assign is_insert = (mode_ff == MODE_INSERT);
   assign new_node  = next_free_ff[NODE_W-1:0];

   // The node's link word with the followed side pointing to a new node.
   always_comb begin
      links_upd = node_links;
      if (ksr_stat.msb) begin
         links_upd[LINK_W-1:NODE_W] = new_node;
      end else begin
         links_upd[NODE_W-1:0] = new_node;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;

   // Walk sequencer: check pass, optional update pass, then result hand-off.
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      first_in      = first_ff;
      new_in        = new_ff;
      node_in       = node_ff;
      present_in    = present_ff;
      sat_in        = sat_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      next_free_in  = next_free_ff;
      root_zero_in  = root_zero_ff;
      root_one_in   = root_one_ff;
      root_count_in = root_count_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      ksr_ctl       = '0;
      link_we       = 1'b0;
      link_wdata    = links_upd;
      count_we      = 1'b0;
      count_wdata   = is_insert ? node_count + COUNT_W'(1) : node_count - COUNT_W'(1);
      rd_node       = child;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ksr_ctl.load = 1'b1;
               mode_in      = req_mode;
               first_in     = 1'b1;
               new_in       = 1'b0;
               node_in      = '0;
               present_in   = 1'b1;
               sat_in       = 1'b0;
               state_in     = S_CHECK;
            end
         end

         S_CHECK: begin
            present_in = present_now;
            sat_in     = sat_now;
            if (!ksr_stat.done && !child_missing) begin
               // Step down to an existing child.
               ksr_ctl.shift = 1'b1;
               first_in      = 1'b0;
               node_in       = child;
            end else begin
               found_in      = present_end;
               status_in     = STAT_OK;
               state_in      = S_FINISH;
               ksr_ctl.restart = 1'b1;
               first_in      = 1'b1;
               new_in        = 1'b0;
               node_in       = '0;
               case (mode_ff)
                  MODE_INSERT: begin
                     if (sat_now) begin
                        status_in = STAT_SATURATED;
                     end else if (pool_short) begin
                        status_in = STAT_POOL_FULL;
                     end else begin
                        state_in = S_UPDATE;
                     end
                  end
                  MODE_ERASE: begin
                     if (present_end) begin
                        state_in = S_UPDATE;
                     end else begin
                        status_in = STAT_ABSENT;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end

         S_UPDATE: begin
            // Count update of the current node.
            if (first_ff) begin
               root_count_in = count_wdata;
            end else begin
               count_we = 1'b1;
            end
            if (!ksr_stat.done) begin
               ksr_ctl.shift = 1'b1;
               first_in      = 1'b0;
               if (is_insert && child_missing) begin
                  // Allocate the next free node and link it in.
                  next_free_in = next_free_ff + FREE_W'(1);
                  node_in      = new_node;
                  new_in       = 1'b1;
                  rd_node      = new_node;
                  if (first_ff) begin
                     root_zero_in = links_upd[NODE_W-1:0];
                     root_one_in  = links_upd[LINK_W-1:NODE_W];
                  end else begin
                     link_we = 1'b1;
                  end
               end else begin
                  node_in = child;
                  new_in  = 1'b0;
               end
            end else begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = found_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      first_ff      <= first_in;
      new_ff        <= new_in;
      node_ff       <= node_in;
      present_ff    <= present_in;
      sat_ff        <= sat_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         next_free_ff  <= FREE_W'(1);
         root_zero_ff  <= '0;
         root_one_ff   <= '0;
         root_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_free_ff  <= next_free_in;
         root_zero_ff  <= root_zero_in;
         root_one_ff   <= root_one_in;
         root_count_ff <= root_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

endmodule
